[rtl/e2c_pkg.sv]
// shared types, constants and calendar tables for the epoch to calendar converter
`default_nettype none

package e2c_pkg;

  // one converted item travelling from the date pipeline to the saving-time pipeline
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] days;
    logic [16:0] sod;
  } date_item_t;

  // saving-time boundary settings
  typedef struct packed {
    logic [3:0] start_month;
    logic [3:0] start_nth;
    logic [4:0] start_hour;
    logic [3:0] end_month;
    logic [3:0] end_nth;
    logic [4:0] end_hour;
  } dst_cfg_t;

  // configuration register indexes
  localparam logic [2:0] REG_START_MONTH = 3'd0;
  localparam logic [2:0] REG_START_NTH   = 3'd1;
  localparam logic [2:0] REG_START_HOUR  = 3'd2;
  localparam logic [2:0] REG_END_MONTH   = 3'd3;
  localparam logic [2:0] REG_END_NTH     = 3'd4;
  localparam logic [2:0] REG_END_HOUR    = 3'd5;

  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [19:0] DAY_SHIFT     = 20'd719468;
  localparam logic [19:0] ERA4_BASE     = 20'd584388;
  localparam logic [19:0] ERA5_BASE     = 20'd730485;
  localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
  localparam logic [11:0] BASE_YEAR     = 12'd1970;
  localparam logic [11:0] SKIP_LEAP     = 12'd2100;

  // reciprocal constants: q = (x * M) >> SH, exact for every x below 2**XW
  localparam int unsigned DAY_XW = 25;
  localparam int unsigned DAY_SH = 35;
  localparam longint unsigned DAY_M = ((64'd1 << DAY_SH) + 64'd674) / 64'd675;
  localparam int unsigned DAY_PW = DAY_XW + $clog2(DAY_M + 64'd1);

  localparam int unsigned HR_XW = 13;
  localparam int unsigned HR_SH = 21;
  localparam longint unsigned HR_M = ((64'd1 << HR_SH) + 64'd224) / 64'd225;
  localparam int unsigned HR_PW = HR_XW + $clog2(HR_M + 64'd1);

  localparam int unsigned MN_XW = 10;
  localparam int unsigned MN_SH = 14;
  localparam longint unsigned MN_M = ((64'd1 << MN_SH) + 64'd14) / 64'd15;
  localparam int unsigned MN_PW = MN_XW + $clog2(MN_M + 64'd1);

  localparam int unsigned DA_XW = 18;
  localparam int unsigned DA_SH = 29;
  localparam longint unsigned DA_M = ((64'd1 << DA_SH) + 64'd1459) / 64'd1460;
  localparam int unsigned DA_PW = DA_XW + $clog2(DA_M + 64'd1);

  localparam int unsigned DB_XW = 18;
  localparam int unsigned DB_SH = 34;
  localparam longint unsigned DB_M = ((64'd1 << DB_SH) + 64'd36523) / 64'd36524;
  localparam int unsigned DB_PW = DB_XW + $clog2(DB_M + 64'd1);

  localparam int unsigned YR_XW = 18;
  localparam int unsigned YR_SH = 27;
  localparam longint unsigned YR_M = ((64'd1 << YR_SH) + 64'd364) / 64'd365;
  localparam int unsigned YR_PW = YR_XW + $clog2(YR_M + 64'd1);

  localparam int unsigned CE_XW = 9;
  localparam int unsigned CE_SH = 16;
  localparam longint unsigned CE_M = ((64'd1 << CE_SH) + 64'd99) / 64'd100;
  localparam int unsigned CE_PW = CE_XW + $clog2(CE_M + 64'd1);

  localparam int unsigned MP_XW = 11;
  localparam int unsigned MP_SH = 19;
  localparam longint unsigned MP_M = ((64'd1 << MP_SH) + 64'd152) / 64'd153;
  localparam int unsigned MP_PW = MP_XW + $clog2(MP_M + 64'd1);

  localparam int unsigned WK_XW = 16;
  localparam int unsigned WK_SH = 19;
  localparam longint unsigned WK_M = ((64'd1 << WK_SH) + 64'd6) / 64'd7;
  localparam int unsigned WK_PW = WK_XW + $clog2(WK_M + 64'd1);

  // first day of each month in a year that starts in march
  function automatic logic [8:0] mp_day_offset(logic [3:0] mp);
    logic [8:0] off;
    case (mp)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  function automatic logic [8:0] days_before_month(logic [3:0] month);
    logic [8:0] n;
    case (month)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] month, logic leap);
    logic [4:0] n;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   n = 5'd30;
      4'd2:                                      n = leap ? 5'd29 : 5'd28;
      default:                                   n = 5'd1;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/e2c_in_if.sv]
// input channel: one unix time stamp per item
`default_nettype none

interface e2c_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

[rtl/e2c_out_if.sv]
// output channel: calendar date, time of day and saving-time flags
`default_nettype none

interface e2c_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] cal_year;
  logic [3:0]  cal_month;
  logic [4:0]  cal_day;
  logic [4:0]  clock_hour;
  logic [5:0]  clock_minute;
  logic [5:0]  clock_second;
  logic        in_dst;
  logic        dst_error;

  modport source (
    output valid, output cal_year, output cal_month, output cal_day,
    output clock_hour, output clock_minute, output clock_second,
    output in_dst, output dst_error, input ready
  );
  modport sink (
    input valid, input cal_year, input cal_month, input cal_day,
    input clock_hour, input clock_minute, input clock_second,
    input in_dst, input dst_error, output ready
  );
endinterface

`default_nettype wire

[rtl/e2c_date.sv]
// ten-stage pipeline from unix seconds to civil date and time of day
`default_nettype none

module e2c_date
  import e2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  e2c_in_if.sink     up,
  output logic       dn_valid,
  input  logic       dn_ready,
  output date_item_t dn_item
);

  localparam int NST = 10;

  logic [NST-1:0] vld;
  logic [NST:0]   go;

  assign go[NST] = dn_ready;
  for (genvar g = 0; g < NST; g++) begin : g_go
    assign go[g] = !vld[g] || go[g+1];
  end

  assign up.ready = go[0];
  assign dn_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (go[NST-1:0] & {vld[NST-2:0], up.valid}) | (~go[NST-1:0] & vld);
    end
  end

  // stage 0: day count by reciprocal of 86400 / 128
  logic [DAY_PW-1:0] day_prod;
  logic [31:0]       s0_t;
  logic [15:0]       s0_days;

  assign day_prod = DAY_PW'(up.epoch_seconds[31:7]) * DAY_PW'(DAY_M);

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s0_t    <= up.epoch_seconds;
      s0_days <= 16'(day_prod >> DAY_SH);
    end
  end

  // stage 1: second of day
  logic [31:0] day_base;
  logic [15:0] s1_days;
  logic [16:0] s1_sod;

  assign day_base = 32'(s0_days) * SECS_PER_DAY;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s1_days <= s0_days;
      s1_sod  <= 17'(s0_t - day_base);
    end
  end

  // stage 2: hour, era and day of era
  logic [HR_PW-1:0] hr_prod;
  logic [19:0]      z;
  logic             era5;
  logic [15:0]      s2_days;
  logic [16:0]      s2_sod;
  logic [4:0]       s2_hour;
  logic [17:0]      s2_doe;
  logic             s2_era5;

  assign hr_prod = HR_PW'(s1_sod[16:4]) * HR_PW'(HR_M);
  assign z       = 20'(s1_days) + DAY_SHIFT;
  assign era5    = z >= ERA5_BASE;

  always_ff @(posedge clk) begin
    if (go[2]) begin
      s2_days <= s1_days;
      s2_sod  <= s1_sod;
      s2_hour <= 5'(hr_prod >> HR_SH);
      s2_doe  <= 18'(z - (era5 ? ERA5_BASE : ERA4_BASE));
      s2_era5 <= era5;
    end
  end

  // stage 3: seconds within the hour, leap corrections of the era
  logic [DA_PW-1:0] da_prod;
  logic [DB_PW-1:0] db_prod;
  logic [15:0]      s3_days;
  logic [16:0]      s3_sod;
  logic [4:0]       s3_hour;
  logic [11:0]      s3_remh;
  logic [17:0]      s3_doe;
  logic             s3_era5;
  logic [6:0]       s3_a;
  logic [2:0]       s3_b;
  logic             s3_c;

  assign da_prod = DA_PW'(s2_doe) * DA_PW'(DA_M);
  assign db_prod = DB_PW'(s2_doe) * DB_PW'(DB_M);

  always_ff @(posedge clk) begin
    if (go[3]) begin
      s3_days <= s2_days;
      s3_sod  <= s2_sod;
      s3_hour <= s2_hour;
      s3_remh <= 12'(s2_sod - 17'(s2_hour) * SECS_PER_HOUR);
      s3_doe  <= s2_doe;
      s3_era5 <= s2_era5;
      s3_a    <= 7'(da_prod >> DA_SH);
      s3_b    <= 3'(db_prod >> DB_SH);
      s3_c    <= s2_doe == ERA_LAST_DAY;
    end
  end

  // stage 4: minute, leap-free day index
  logic [MN_PW-1:0] mn_prod;
  logic [15:0]      s4_days;
  logic [16:0]      s4_sod;
  logic [4:0]       s4_hour;
  logic [11:0]      s4_remh;
  logic [17:0]      s4_doe;
  logic             s4_era5;
  logic [17:0]      s4_n;
  logic [5:0]       s4_min;

  assign mn_prod = MN_PW'(s3_remh[11:2]) * MN_PW'(MN_M);

  always_ff @(posedge clk) begin
    if (go[4]) begin
      s4_days <= s3_days;
      s4_sod  <= s3_sod;
      s4_hour <= s3_hour;
      s4_remh <= s3_remh;
      s4_doe  <= s3_doe;
      s4_era5 <= s3_era5;
      s4_n    <= s3_doe - 18'(s3_a) + 18'(s3_b) - 18'(s3_c);
      s4_min  <= 6'(mn_prod >> MN_SH);
    end
  end

  // stage 5: second, year of era
  logic [YR_PW-1:0] yr_prod;
  logic [15:0]      s5_days;
  logic [16:0]      s5_sod;
  logic [4:0]       s5_hour;
  logic [5:0]       s5_min;
  logic [5:0]       s5_sec;
  logic [17:0]      s5_doe;
  logic             s5_era5;
  logic [8:0]       s5_yoe;

  assign yr_prod = YR_PW'(s4_n) * YR_PW'(YR_M);

  always_ff @(posedge clk) begin
    if (go[5]) begin
      s5_days <= s4_days;
      s5_sod  <= s4_sod;
      s5_hour <= s4_hour;
      s5_min  <= s4_min;
      s5_sec  <= 6'(s4_remh - 12'(s4_min) * 12'd60);
      s5_doe  <= s4_doe;
      s5_era5 <= s4_era5;
      s5_yoe  <= 9'(yr_prod >> YR_SH);
    end
  end

  // stage 6: centuries within the era
  logic [CE_PW-1:0] ce_prod;
  logic [15:0]      s6_days;
  logic [16:0]      s6_sod;
  logic [4:0]       s6_hour;
  logic [5:0]       s6_min;
  logic [5:0]       s6_sec;
  logic [17:0]      s6_doe;
  logic             s6_era5;
  logic [8:0]       s6_yoe;
  logic [1:0]       s6_c100;

  assign ce_prod = CE_PW'(s5_yoe) * CE_PW'(CE_M);

  always_ff @(posedge clk) begin
    if (go[6]) begin
      s6_days <= s5_days;
      s6_sod  <= s5_sod;
      s6_hour <= s5_hour;
      s6_min  <= s5_min;
      s6_sec  <= s5_sec;
      s6_doe  <= s5_doe;
      s6_era5 <= s5_era5;
      s6_yoe  <= s5_yoe;
      s6_c100 <= 2'(ce_prod >> CE_SH);
    end
  end

  // stage 7: day of the march-based year and the march-based year number
  logic [17:0] year_start;
  logic [15:0] s7_days;
  logic [16:0] s7_sod;
  logic [4:0]  s7_hour;
  logic [5:0]  s7_min;
  logic [5:0]  s7_sec;
  logic [8:0]  s7_doy;
  logic [11:0] s7_y;

  assign year_start = 18'(s6_yoe) * 18'd365 + 18'(s6_yoe[8:2]) - 18'(s6_c100);

  always_ff @(posedge clk) begin
    if (go[7]) begin
      s7_days <= s6_days;
      s7_sod  <= s6_sod;
      s7_hour <= s6_hour;
      s7_min  <= s6_min;
      s7_sec  <= s6_sec;
      s7_doy  <= 9'(s6_doe - year_start);
      s7_y    <= 12'(s6_yoe) + (s6_era5 ? 12'd2000 : 12'd1600);
    end
  end

  // stage 8: month index counted from march
  logic [MP_XW-1:0] mp_x;
  logic [MP_PW-1:0] mp_prod;
  logic [15:0]      s8_days;
  logic [16:0]      s8_sod;
  logic [4:0]       s8_hour;
  logic [5:0]       s8_min;
  logic [5:0]       s8_sec;
  logic [8:0]       s8_doy;
  logic [11:0]      s8_y;
  logic [3:0]       s8_mp;

  assign mp_x    = 11'(s7_doy) * 11'd5 + 11'd2;
  assign mp_prod = MP_PW'(mp_x) * MP_PW'(MP_M);

  always_ff @(posedge clk) begin
    if (go[8]) begin
      s8_days <= s7_days;
      s8_sod  <= s7_sod;
      s8_hour <= s7_hour;
      s8_min  <= s7_min;
      s8_sec  <= s7_sec;
      s8_doy  <= s7_doy;
      s8_y    <= s7_y;
      s8_mp   <= 4'(mp_prod >> MP_SH);
    end
  end

  // stage 9: day and month, january and february belong to the next year
  logic [3:0]  month;
  logic [8:0]  day_full;
  date_item_t  s9_item;

  assign month    = (s8_mp < 4'd10) ? s8_mp + 4'd3 : s8_mp - 4'd9;
  assign day_full = s8_doy - mp_day_offset(s8_mp) + 9'd1;

  always_ff @(posedge clk) begin
    if (go[9]) begin
      s9_item.year   <= s8_y + 12'(month <= 4'd2);
      s9_item.month  <= month;
      s9_item.day    <= day_full[4:0];
      s9_item.hour   <= s8_hour;
      s9_item.minute <= s8_min;
      s9_item.second <= s8_sec;
      s9_item.days   <= s8_days;
      s9_item.sod    <= s8_sod;
    end
  end

  assign dn_item = s9_item;

endmodule

`default_nettype wire

[rtl/e2c_dst.sv]
// five-stage pipeline that places the saving-time boundaries and flags the item
`default_nettype none

module e2c_dst
  import e2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dst_cfg_t   cfg,
  input  logic       up_valid,
  output logic       up_ready,
  input  date_item_t up_item,
  e2c_out_if.source  dn
);

  localparam int NST = 5;

  logic [NST-1:0] vld;
  logic [NST:0]   go;

  assign go[NST] = dn.ready;
  for (genvar g = 0; g < NST; g++) begin : g_go
    assign go[g] = !vld[g] || go[g+1];
  end

  assign up_ready = go[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= (go[NST-1:0] & {vld[NST-2:0], up_valid}) | (~go[NST-1:0] & vld);
    end
  end

  // day number of the first day, or the last day when counting back
  function automatic logic [15:0] anchor_day(logic [15:0] ys, logic leap,
                                             logic [3:0] month, logic from_end);
    logic [15:0] bd;
    bd = ys + 16'(days_before_month(month)) + 16'(month > 4'd2 && leap);
    if (from_end) begin
      bd = bd + 16'(month_days(month, leap)) - 16'd1;
    end
    return bd;
  endfunction

  // walk from the anchor day to the wanted sunday
  function automatic logic signed [17:0] sunday_day(logic [15:0] bd, logic [2:0] wd,
                                                    logic [3:0] nth);
    logic [2:0]         k;
    logic [2:0]         back;
    logic [5:0]         span;
    logic signed [17:0] base;
    logic signed [17:0] step;
    k    = nth[3] ? ~nth[2:0] : nth[2:0] - 3'd1;
    back = (wd == 3'd6) ? 3'd0 : wd + 3'd1;
    span = (nth[3] ? 6'(back) : 6'(3'd6 - wd)) + 6'(k) * 6'd7;
    base = $signed({2'b00, bd});
    step = $signed({12'd0, span});
    return nth[3] ? base - step : base + step;
  endfunction

  // true once the item's moment is at or past the given day and hour
  function automatic logic reached(logic [15:0] days, logic [16:0] sod,
                                   logic signed [17:0] ds, logic [4:0] hour);
    logic signed [17:0] dn_s;
    logic [16:0]        hs;
    dn_s = $signed({2'b00, days});
    hs   = 17'(hour) * SECS_PER_HOUR;
    return (dn_s > ds) || (dn_s == ds && sod >= hs);
  endfunction

  function automatic logic bound_ok(logic [3:0] month, logic [3:0] nth, logic [4:0] hour);
    return month >= 4'd1 && month <= 4'd12 && hour <= 5'd23 && nth != 4'd0 &&
           $signed(nth) >= -4'sd5 && $signed(nth) <= 4'sd5;
  endfunction

  // stage 0: first day of the year and leap flag
  logic [7:0]  yoff;
  logic [15:0] ys;
  logic        leap;
  date_item_t  d0_item;
  logic [15:0] d0_ys;
  logic        d0_leap;

  assign yoff = 8'(up_item.year - BASE_YEAR);
  assign ys   = 16'(yoff) * 16'd365 + 16'((9'(yoff) + 9'd1) >> 2)
              - 16'(up_item.year > SKIP_LEAP);
  assign leap = up_item.year[1:0] == 2'b00 && up_item.year != SKIP_LEAP;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      d0_item <= up_item;
      d0_ys   <= ys;
      d0_leap <= leap;
    end
  end

  // stage 1: anchor days of both boundaries
  date_item_t  d1_item;
  logic [15:0] d1_bd_s;
  logic [15:0] d1_bd_e;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      d1_item <= d0_item;
      d1_bd_s <= anchor_day(d0_ys, d0_leap, cfg.start_month, cfg.start_nth[3]);
      d1_bd_e <= anchor_day(d0_ys, d0_leap, cfg.end_month, cfg.end_nth[3]);
    end
  end

  // stage 2: weeks since a known monday
  logic [WK_XW-1:0] wx_s;
  logic [WK_XW-1:0] wx_e;
  logic [WK_PW-1:0] wk_prod_s;
  logic [WK_PW-1:0] wk_prod_e;
  date_item_t       d2_item;
  logic [15:0]      d2_bd_s;
  logic [15:0]      d2_bd_e;
  logic [12:0]      d2_q_s;
  logic [12:0]      d2_q_e;

  assign wx_s      = d1_bd_s + 16'd3;
  assign wx_e      = d1_bd_e + 16'd3;
  assign wk_prod_s = WK_PW'(wx_s) * WK_PW'(WK_M);
  assign wk_prod_e = WK_PW'(wx_e) * WK_PW'(WK_M);

  always_ff @(posedge clk) begin
    if (go[2]) begin
      d2_item <= d1_item;
      d2_bd_s <= d1_bd_s;
      d2_bd_e <= d1_bd_e;
      d2_q_s  <= 13'(wk_prod_s >> WK_SH);
      d2_q_e  <= 13'(wk_prod_e >> WK_SH);
    end
  end

  // stage 3: weekday (monday 0) and the boundary sunday
  logic [15:0]        wr_s;
  logic [15:0]        wr_e;
  date_item_t         d3_item;
  logic signed [17:0] d3_ds_s;
  logic signed [17:0] d3_ds_e;

  assign wr_s = d2_bd_s + 16'd3 - 16'(d2_q_s) * 16'd7;
  assign wr_e = d2_bd_e + 16'd3 - 16'(d2_q_e) * 16'd7;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      d3_item <= d2_item;
      d3_ds_s <= sunday_day(d2_bd_s, wr_s[2:0], cfg.start_nth);
      d3_ds_e <= sunday_day(d2_bd_e, wr_e[2:0], cfg.end_nth);
    end
  end

  // stage 4: output register
  logic       cfg_ok;
  date_item_t d4_item;
  logic       d4_in_dst;
  logic       d4_error;

  assign cfg_ok = bound_ok(cfg.start_month, cfg.start_nth, cfg.start_hour) &&
                  bound_ok(cfg.end_month, cfg.end_nth, cfg.end_hour);

  always_ff @(posedge clk) begin
    if (go[4]) begin
      d4_item   <= d3_item;
      d4_error  <= !cfg_ok;
      d4_in_dst <= cfg_ok &&
                   reached(d3_item.days, d3_item.sod, d3_ds_s, cfg.start_hour) &&
                   !reached(d3_item.days, d3_item.sod, d3_ds_e, cfg.end_hour);
    end
  end

  assign dn.valid        = vld[NST-1];
  assign dn.cal_year     = d4_item.year;
  assign dn.cal_month    = d4_item.month;
  assign dn.cal_day      = d4_item.day;
  assign dn.clock_hour   = d4_item.hour;
  assign dn.clock_minute = d4_item.minute;
  assign dn.clock_second = d4_item.second;
  assign dn.in_dst       = d4_in_dst;
  assign dn.dst_error    = d4_error;

endmodule

`default_nettype wire

[rtl/epoch_to_calendar_with_dst.sv]
// Unix time to calendar date and time of day with a daylight saving flag.
// The epoch channel takes one 32-bit count of seconds since 1970-01-01 UTC per item;
// the calendar channel returns year, month, day, hour, minute, second, in_dst and
// dst_error for it, in order, one result per item.
// Both channels are valid/ready; an item moves on a rising edge with both high.
// The configuration port writes one saving-time register per cycle while cfg_we is
// high: 0 start month, 1 start nth Sunday, 2 start hour, 3 end month, 4 end nth,
// 5 end hour; other indexes are ignored. Write only while no item is in flight.
// An item passes ten date stages, then five saving-time stages, the last of which is
// the output register.
// Throughput: one item per cycle while the receiver is ready; the longest stage is one
// constant multiply with a short add, subtract or compare behind it.
// When the receiver stalls, the pipeline holds its items and keeps accepting new
// ones until every stage is full; nothing is dropped or repeated.
// Reset empties the pipeline and loads the saving-time registers with march and
// october, last Sunday, 01:00.
`default_nettype none

module epoch_to_calendar_with_dst
  import e2c_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  e2c_in_if.sink     epoch,
  e2c_out_if.source  calendar,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_wdata
);

  dst_cfg_t   cfg;
  logic       mid_valid;
  logic       mid_ready;
  date_item_t mid_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_month <= 4'd3;
      cfg.start_nth   <= 4'hF;
      cfg.start_hour  <= 5'd1;
      cfg.end_month   <= 4'd10;
      cfg.end_nth     <= 4'hF;
      cfg.end_hour    <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_MONTH: cfg.start_month <= cfg_wdata[3:0];
        REG_START_NTH:   cfg.start_nth   <= cfg_wdata[3:0];
        REG_START_HOUR:  cfg.start_hour  <= cfg_wdata;
        REG_END_MONTH:   cfg.end_month   <= cfg_wdata[3:0];
        REG_END_NTH:     cfg.end_nth     <= cfg_wdata[3:0];
        REG_END_HOUR:    cfg.end_hour    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  e2c_date u_date (
    .clk      (clk),
    .rst      (rst),
    .up       (epoch),
    .dn_valid (mid_valid),
    .dn_ready (mid_ready),
    .dn_item  (mid_item)
  );

  e2c_dst u_dst (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (mid_valid),
    .up_ready (mid_ready),
    .up_item  (mid_item),
    .dn       (calendar)
  );

endmodule

`default_nettype wire

[tb/epoch_to_calendar_with_dst_tb.sv]
// testbench for the epoch to calendar converter: each result is checked against a predictor
module epoch_to_calendar_with_dst_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import e2c_pkg::*;

  localparam int SETTLE_CYCLES  = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        in_dst;
    logic        dst_error;
  } calendar_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [4:0] cfg_wdata;

  e2c_in_if  epoch_ch ();
  e2c_out_if cal_ch ();

  epoch_to_calendar_with_dst DUT (
    .clk       (clk),
    .rst       (rst),
    .epoch     (epoch_ch),
    .calendar  (cal_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // rule registers as the block holds them, starting from the reset values
  dst_cfg_t  rules = '{4'd3, 4'(-1), 5'd1, 4'd10, 4'(-1), 5'd1};
  calendar_t expected_dates[$];

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  int hold_request;
  int quiet_cycles;
  int mismatches;
  int stray_results;
  int items_accepted;
  int results_checked;
  int dst_seen;
  int bad_rules_seen;
  int rule_sets;

  function automatic bit is_leap(int unsigned yr);
    return (yr % 4 == 0 && yr % 100 != 0) || yr % 400 == 0;
  endfunction

  function automatic int year_days(int unsigned yr);
    return is_leap(yr) ? 366 : 365;
  endfunction

  function automatic int month_len(int unsigned yr, int unsigned mon);
    case (mon)
      2:             return is_leap(yr) ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic longint leaps_upto(int unsigned n);
    return longint'(n / 4 - n / 100 + n / 400);
  endfunction

  // days since 1970-01-01
  function automatic longint epoch_day(int unsigned yr, int unsigned mon, int unsigned dy);
    longint n;
    int unsigned k;
    n = 365 * longint'(yr - 1970) + leaps_upto(yr - 1) - leaps_upto(1969);
    for (k = 1; k < mon; k++) n += month_len(yr, k);
    return n + longint'(dy) - 1;
  endfunction

  // start or end of saving time in seconds, at full width; 0 when the rule is invalid
  function automatic bit sunday_moment(int unsigned yr, logic [3:0] mon, logic [3:0] nth_code,
                                       logic [4:0] hr, output longint at);
    int     nth;
    longint day_no;
    longint wd;
    at = 0;
    nth = int'($signed(nth_code));
    if (nth == 0 || nth > 5 || nth < -5 || mon < 1 || mon > 12 || hr > 23) return 1'b0;
    day_no = epoch_day(yr, mon, (nth > 0) ? 1 : month_len(yr, mon));
    // monday 0 .. sunday 6
    wd = (day_no + 3) % 7;
    if (nth > 0) day_no += 6 - wd + 7 * (nth - 1);
    else day_no -= (wd + 1) % 7 + 7 * (-nth - 1);
    at = day_no * 86400 + longint'(hr) * 3600;
    return 1'b1;
  endfunction

  function automatic calendar_t predict_calendar(logic [31:0] t, dst_cfg_t c);
    calendar_t   r;
    int unsigned rem;
    int unsigned sod;
    int unsigned yr;
    int unsigned mon;
    longint      start_at;
    longint      end_at;
    longint      now;
    bit          start_ok;
    bit          end_ok;
    rem = t / 32'd86400;
    sod = t % 32'd86400;
    yr = 1970;
    while (rem >= year_days(yr)) begin
      rem -= year_days(yr);
      yr++;
    end
    mon = 1;
    while (rem >= month_len(yr, mon)) begin
      rem -= month_len(yr, mon);
      mon++;
    end
    start_ok = sunday_moment(yr, c.start_month, c.start_nth, c.start_hour, start_at);
    end_ok = sunday_moment(yr, c.end_month, c.end_nth, c.end_hour, end_at);
    now = longint'({32'd0, t});
    r.year = 12'(yr);
    r.month = 4'(mon);
    r.day = 5'(rem + 1);
    r.hour = 5'(sod / 3600);
    r.minute = 6'((sod / 60) % 60);
    r.second = 6'(sod % 60);
    r.dst_error = !(start_ok && end_ok);
    r.in_dst = start_ok && end_ok && now >= start_at && now < end_at;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [3:0] random_nth();
    int n;
    n = $urandom_range(9, 0);
    return (n < 5) ? 4'(n + 1) : 4'(4 - n);
  endfunction

  function automatic dst_cfg_t random_rules(bit wild);
    dst_cfg_t c;
    if (wild) begin
      c.start_month = 4'($urandom);
      c.start_nth = 4'($urandom);
      c.start_hour = 5'($urandom);
      c.end_month = 4'($urandom);
      c.end_nth = 4'($urandom);
      c.end_hour = 5'($urandom);
    end else begin
      c.start_month = 4'($urandom_range(12, 1));
      c.start_nth = random_nth();
      c.start_hour = 5'($urandom_range(23, 0));
      c.end_month = 4'($urandom_range(12, 1));
      c.end_nth = random_nth();
      c.end_hour = 5'($urandom_range(23, 0));
    end
    return c;
  endfunction

  // uniform time stamps mixed with ones close to a saving-time boundary
  function automatic logic [31:0] random_epoch();
    int unsigned yr;
    longint      at;
    longint      span;
    bit          ok;
    if ($urandom_range(99) < 40) return $urandom;
    yr = $urandom_range(2106, 1970);
    if ($urandom_range(1))
      ok = sunday_moment(yr, rules.start_month, rules.start_nth, rules.start_hour, at);
    else
      ok = sunday_moment(yr, rules.end_month, rules.end_nth, rules.end_hour, at);
    case ($urandom_range(3))
      0:       span = 1;
      1:       span = 3600;
      2:       span = 3 * 86400;
      default: span = 40 * 86400;
    endcase
    at += longint'($urandom_range(32'(2 * span))) - span;
    if (!ok || at < 0 || at > 64'hFFFF_FFFF) return $urandom;
    return at[31:0];
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // offer one item and hold it until the block takes it; valid stays high afterwards
  task automatic send_epoch(logic [31:0] value);
    int gap;
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      epoch_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    epoch_ch.valid <= 1'b1;
    epoch_ch.epoch_seconds <= value;
    do @(posedge clk); while (!epoch_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    epoch_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_dates.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [4:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
  endtask

  task automatic apply_rules(dst_cfg_t c);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_START_MONTH, {1'b0, c.start_month});
    write_reg(REG_START_NTH, {1'b0, c.start_nth});
    write_reg(REG_START_HOUR, c.start_hour);
    write_reg(REG_END_MONTH, {1'b0, c.end_month});
    write_reg(REG_END_NTH, {1'b0, c.end_nth});
    write_reg(REG_END_HOUR, c.end_hour);
    // indexes past the last register must leave the rules alone
    write_reg(REG_END_HOUR + 3'(1 + $urandom_range(1)), 5'($urandom));
    cfg_we <= 1'b0;
    rules = c;
    rule_sets++;
  endtask

  task automatic test_calendar_edges();
    send_epoch(32'd0);
    send_epoch(32'd1);
    send_epoch(32'd86399);
    send_epoch(32'd86400);
    send_epoch(32'd68169600);    // 1972-02-29
    send_epoch(32'd946684799);   // last second of 1999
    send_epoch(32'd951782400);   // 2000-02-29
    send_epoch(32'd4107542399);  // 2100-02-28 23:59:59, no leap day follows
    send_epoch(32'd4107542400);
    send_epoch(32'h7FFF_FFFF);
    send_epoch(32'hFFFF_FFFF);
  endtask

  task automatic test_dst_edges();
    dst_cfg_t c;
    longint   start_at;
    longint   end_at;
    c = rules;
    void'(sunday_moment(2021, c.start_month, c.start_nth, c.start_hour, start_at));
    void'(sunday_moment(2021, c.end_month, c.end_nth, c.end_hour, end_at));
    send_epoch(32'(start_at - 1));
    send_epoch(32'(start_at));
    send_epoch(32'(end_at - 1));
    send_epoch(32'(end_at));

    // zero nth flags the rule and clears the flag
    c.start_nth = 4'd0;
    apply_rules(c);
    send_epoch(32'(start_at));
    send_epoch($urandom);

    // start after end leaves the interval empty
    apply_rules('{4'd10, 4'(-1), 5'd1, 4'd3, 4'(-1), 5'd1});
    send_epoch(32'(start_at + 100 * 86400));
    send_epoch(32'(start_at - 60 * 86400));

    // no fifth sunday in february 2021, the count runs into march
    c = '{4'd2, 4'd5, 5'd0, 4'd11, 4'(-5), 5'd23};
    apply_rules(c);
    void'(sunday_moment(2021, c.start_month, c.start_nth, c.start_hour, start_at));
    send_epoch(32'(start_at - 1));
    send_epoch(32'(start_at));

    // boundaries before 1970 and past the 32-bit range
    apply_rules('{4'd1, 4'(-5), 5'd0, 4'd12, 4'd5, 5'd23});
    send_epoch(32'd0);
    send_epoch(32'hFFFF_FFFF);
  endtask

  task automatic test_rule_sweep();
    dst_cfg_t c;
    int       phase;
    int       k;
    for (phase = 0; phase < 14; phase++) begin
      case (phase)
        0:       c = '{4'd1, 4'd1, 5'd0, 4'd12, 4'(-5), 5'd23};
        1:       c = '{4'd12, 4'd5, 5'd23, 4'd1, 4'd1, 5'd0};
        2:       c = '{4'd0, 4'd1, 5'd1, 4'd10, 4'(-1), 5'd1};
        3:       c = '{4'd15, 4'd7, 5'd31, 4'd15, 4'(-8), 5'd31};
        4:       c = '{4'd3, 4'(-7), 5'd1, 4'd13, 4'd6, 5'd24};
        5:       c = '{4'd2, 4'd5, 5'd0, 4'd2, 4'(-5), 5'd23};
        default: c = random_rules(phase % 3 == 0);
      endcase
      apply_rules(c);
      for (k = 0; k < 90; k++) send_epoch(random_epoch());
    end
  endtask

  task automatic test_full_rate();
    int k;
    apply_rules(random_rules(1'b0));
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    for (k = 0; k < 200; k++) send_epoch(random_epoch());
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_backpressure();
    int k;
    hold_request = HOLD_CYCLES;
    tx_gaps = 1'b0;
    for (k = 0; k < 60; k++) send_epoch(random_epoch());
    tx_gaps = 1'b1;
  endtask

  task automatic test_sender_pause();
    int k;
    for (k = 0; k < 40; k++) send_epoch(random_epoch());
    wait_for_results();
    for (k = 0; k < 40; k++) send_epoch(random_epoch());
  endtask

  initial begin : receiver
    int stall;
    stall = 0;
    cal_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        cal_ch.ready <= 1'b0;
        stall--;
      end else if (!rx_gaps) begin
        cal_ch.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        cal_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  always @(posedge clk) begin : scoreboard
    calendar_t got;
    calendar_t want;
    if (!rst) begin
      if (cal_ch.valid && cal_ch.ready) begin
        got = '{cal_ch.cal_year, cal_ch.cal_month, cal_ch.cal_day, cal_ch.clock_hour,
                cal_ch.clock_minute, cal_ch.clock_second, cal_ch.in_dst, cal_ch.dst_error};
        if (expected_dates.size() == 0) begin
          $error("result with no item outstanding: %0d-%0d-%0d", got.year, got.month, got.day);
          stray_results++;
        end else begin
          want = expected_dates.pop_front();
          check_field("cal_year", want.year, got.year);
          check_field("cal_month", want.month, got.month);
          check_field("cal_day", want.day, got.day);
          check_field("clock_hour", want.hour, got.hour);
          check_field("clock_minute", want.minute, got.minute);
          check_field("clock_second", want.second, got.second);
          check_field("in_dst", want.in_dst, got.in_dst);
          check_field("dst_error", want.dst_error, got.dst_error);
          results_checked++;
          dst_seen += got.in_dst;
          bad_rules_seen += got.dst_error;
        end
      end
      if (epoch_ch.valid && epoch_ch.ready) begin
        expected_dates.push_back(predict_calendar(epoch_ch.epoch_seconds, rules));
        items_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (epoch_ch.valid && epoch_ch.ready) || (cal_ch.valid && cal_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("epoch_to_calendar_with_dst_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    epoch_ch.valid = 1'b0;
    epoch_ch.epoch_seconds = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_calendar_edges();
    test_dst_edges();
    test_rule_sweep();
    test_full_rate();
    test_backpressure();
    test_sender_pause();

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("converted %0d time stamps under %0d rule settings, %0d results checked",
             items_accepted, rule_sets + 1, results_checked);
    $display("%0d results inside saving time, %0d with an invalid rule",
             dst_seen, bad_rules_seen);
    if (mismatches == 0 && stray_results == 0) begin
      $display("epoch_to_calendar_with_dst_tb OK");
    end else begin
      $display("epoch_to_calendar_with_dst_tb NOT OK");
    end
    $finish;
  end

endmodule
